/* rtl/core/tdc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tdc_pkg;

	// Nanoseconds in one second; its bits drive the scaling cells.
	localparam logic [31:0] NS_PER_SEC = 32'd1000000000;

	// Largest whole-second count whose product with NS_PER_SEC fits in 64 bits.
	localparam logic [63:0] MAX_WHOLE = 64'd18446744073;

	// Width that holds any whole-second count up to MAX_WHOLE.
	localparam int WHOLE_W = 35;

	// Register indexes of the configuration port.
	localparam logic [1:0] REG_FETCH_BW  = 2'd0;
	localparam logic [1:0] REG_EVICT_BW  = 2'd1;
	localparam logic [1:0] REG_FETCH_LAT = 2'd2;
	localparam logic [1:0] REG_EVICT_LAT = 2'd3;

	// Direction codes of the mode field.
	localparam logic MODE_FETCH = 1'b0;
	localparam logic MODE_EVICT = 1'b1;

	typedef struct packed {
		logic [63:0] size_bytes;
		logic        mode;
	} in_item_t;

	typedef struct packed {
		logic [63:0] runtime_ns;
		logic        saturated;
	} out_item_t;

	// Work carried along the division chain.
	typedef struct packed {
		logic [63:0] dvd;
		logic [63:0] rem;
		logic [63:0] quot;
		logic [63:0] bw;
		logic [63:0] lat;
		logic        sat;
	} div_t;

	// Work carried along the scaling chain.
	typedef struct packed {
		logic [31:0]        q;
		logic [63:0]        r;
		logic [63:0]        frac;
		logic [63:0]        den;
		logic [63:0]        acc;
		logic [WHOLE_W-1:0] whole;
		logic [63:0]        lat;
		logic               sat;
	} scl_t;

endpackage

`default_nettype wire

/* rtl/core/tdc_div_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

// One restoring division step: brings in the next dividend bit.
module tdc_div_cell (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          prev_valid,
	input  wire tdc_pkg::div_t prev,
	output logic               next_valid_s1,
	output tdc_pkg::div_t      next_s1
);

	logic [64:0]   trial;
	logic [64:0]   diff;
	logic          take;
	tdc_pkg::div_t step;

	// Shift in one dividend bit and subtract the divisor when it fits.
	always_comb begin
		trial = {prev.rem, prev.dvd[63]};
		diff  = trial - {1'b0, prev.bw};
		take  = !diff[64];
		step      = prev;
		step.dvd  = {prev.dvd[62:0], 1'b0};
		step.rem  = take ? diff[63:0] : trial[63:0];
		step.quot = {prev.quot[62:0], take};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_valid_s1 <= 1'b0;
		end else if (en) begin
			next_valid_s1 <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			next_s1 <= step;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/tdc_scale_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

// One step of the rounding-up multiply-divide by the nanosecond constant.
module tdc_scale_cell #(
	parameter int BIT = 31
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          prev_valid,
	input  wire tdc_pkg::scl_t prev,
	output logic               next_valid_s1,
	output tdc_pkg::scl_t      next_s1
);

	localparam logic CBIT = tdc_pkg::NS_PER_SEC[BIT];

	logic [63:0]   gap;
	logic [63:0]   r1;
	logic [31:0]   q1;
	logic [63:0]   gap2;
	tdc_pkg::scl_t step;

	// Double the remainder modulo the divisor, then add the fraction if the bit is set.
	always_comb begin
		gap  = prev.den - prev.r;
		q1   = {prev.q[30:0], 1'b0};
		if (prev.r >= gap) begin
			r1 = prev.r - gap;
			q1 = q1 + 32'd1;
		end else begin
			r1 = {prev.r[62:0], 1'b0};
		end
		step     = prev;
		step.acc = {prev.acc[62:0], 1'b0};
		gap2     = prev.den - prev.frac;
		if (CBIT) begin
			step.acc = step.acc + 64'(prev.whole);
			if (r1 >= gap2) begin
				step.r = r1 - gap2;
				step.q = q1 + 32'd1;
			end else begin
				step.r = r1 + prev.frac;
				step.q = q1;
			end
		end else begin
			step.r = r1;
			step.q = q1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_valid_s1 <= 1'b0;
		end else if (en) begin
			next_valid_s1 <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			next_s1 <= step;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/tdc_finish.sv */
`timescale 1ns / 1ps
`default_nettype none

// Adds the whole part, the rounded fraction and the latency, and clamps on overflow.
module tdc_finish (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          prev_valid,
	input  wire tdc_pkg::scl_t prev,
	output logic               out_valid_q,
	output tdc_pkg::out_item_t out_q
);

	logic [64:0]        sum1;
	logic [64:0]        sum2;
	logic               sat;
	tdc_pkg::out_item_t res;

	always_comb begin
		sum1 = {1'b0, prev.acc} + 65'(prev.q) + 65'(prev.r != 64'd0);
		sum2 = {1'b0, sum1[63:0]} + {1'b0, prev.lat};
		sat  = prev.sat | sum1[64] | sum2[64];
		res.runtime_ns = sat ? '1 : sum2[63:0];
		res.saturated  = sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q <= res;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/transfer_duration_calculator.sv */
`timescale 1ns / 1ps
`default_nettype none

// Pipeline: 64 division cells, 32 scaling cells and one output register lie
// between an accepted item and its result, all held while the output stalls.
// Throughput: one item per cycle when not stalled; all cells advance together.
// Reset: arst_n clears all valid bits and loads both bandwidths with 1e9 and
// both latencies with zero.
module transfer_duration_calculator (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire tdc_pkg::in_item_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output tdc_pkg::out_item_t      out_data,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [63:0]        cfg_wdata
);

	logic [63:0] fetch_bw_q;
	logic [63:0] evict_bw_q;
	logic [63:0] fetch_lat_q;
	logic [63:0] evict_lat_q;
	logic        adv;

	logic          div_v   [0:64];
	tdc_pkg::div_t div_d   [0:64];
	logic          scl_v   [0:32];
	tdc_pkg::scl_t scl_d   [0:32];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fetch_bw_q  <= 64'(tdc_pkg::NS_PER_SEC);
			evict_bw_q  <= 64'(tdc_pkg::NS_PER_SEC);
			fetch_lat_q <= '0;
			evict_lat_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tdc_pkg::REG_FETCH_BW:  fetch_bw_q  <= cfg_wdata;
				tdc_pkg::REG_EVICT_BW:  evict_bw_q  <= cfg_wdata;
				tdc_pkg::REG_FETCH_LAT: fetch_lat_q <= cfg_wdata;
				tdc_pkg::REG_EVICT_LAT: evict_lat_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// The chain moves whenever the output register is free or being taken.
	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	// Head of the division chain.
	always_comb begin
		div_v[0]      = in_valid;
		div_d[0].dvd  = in_data.size_bytes;
		div_d[0].rem  = '0;
		div_d[0].quot = '0;
		div_d[0].bw   = (in_data.mode == tdc_pkg::MODE_EVICT) ? evict_bw_q : fetch_bw_q;
		div_d[0].lat  = (in_data.mode == tdc_pkg::MODE_EVICT) ? evict_lat_q : fetch_lat_q;
		div_d[0].sat  = (div_d[0].bw == 64'd0);
	end

	for (genvar i = 0; i < 64; i++) begin : g_div
		tdc_div_cell u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.en            (adv),
			.prev_valid    (div_v[i]),
			.prev          (div_d[i]),
			.next_valid_s1 (div_v[i+1]),
			.next_s1       (div_d[i+1])
		);
	end

	// Hand the quotient and remainder over to the scaling chain.
	always_comb begin
		scl_v[0]       = div_v[64];
		scl_d[0].q     = '0;
		scl_d[0].r     = '0;
		scl_d[0].frac  = div_d[64].rem;
		scl_d[0].den   = div_d[64].bw;
		scl_d[0].acc   = '0;
		scl_d[0].whole = div_d[64].quot[tdc_pkg::WHOLE_W-1:0];
		scl_d[0].lat   = div_d[64].lat;
		scl_d[0].sat   = div_d[64].sat | (div_d[64].quot > tdc_pkg::MAX_WHOLE);
	end

	for (genvar j = 0; j < 32; j++) begin : g_scl
		tdc_scale_cell #(
			.BIT (31 - j)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.en            (adv),
			.prev_valid    (scl_v[j]),
			.prev          (scl_d[j]),
			.next_valid_s1 (scl_v[j+1]),
			.next_s1       (scl_d[j+1])
		);
	end

	tdc_finish u_finish (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (adv),
		.prev_valid  (scl_v[32]),
		.prev        (scl_d[32]),
		.out_valid_q (out_valid),
		.out_q       (out_data)
	);

	// A clamped result always reads as all ones.
	a_sat_ones : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.saturated |-> out_data.runtime_ns == '1)
		else $error("saturated result is not all ones");

	// The input side is held back only by a stalled result.
	a_stall_src : assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a stalled result");

	// An accepted item enters the first division cell.
	a_enter : assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> div_v[1])
		else $error("accepted item lost at the chain head");

endmodule

`default_nettype wire
